// ===== sv/kruskal_union_find_mst_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef KRUSKAL_UNION_FIND_MST_DEFINES_SVH
`define KRUSKAL_UNION_FIND_MST_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define KUMST_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define KUMST_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset.
`define KUMST_ASSERT_ALWAYS(label, clk, cond, prop, msg) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) else $error(msg);

`endif

// ===== sv/kumst_pkg.sv =====
`default_nettype none
package kumst_pkg;

  localparam int VERTEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W = 26;
  localparam int JOINS_W = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic [SUM_W-1:0] SUM_MAX = 26'h3FF_FFFF;
  localparam logic [JOINS_W-1:0] JOIN_MAX = 10'h3FF;

  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_BAD = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic               joined;
    logic [SUM_W-1:0]   total_weight;
    logic [JOINS_W-1:0] edges_joined;
    logic               complete;
    logic               bad_vertex;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [WEIGHT_W-1:0] weight;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/kruskal_union_find_mst.sv =====
// An edge request walks parent links in the link memory from each endpoint up to its root,
// then links the two roots; a bad or post-completion edge goes straight to its result.
// Throughput: one request at a time in the link walker; the front queues up to two more.
// A begin request sweeps the link memory before its result.
// Reset is synchronous; after it the sweep runs and item_ready stays low through the sweep.
`default_nettype none
module kruskal_union_find_mst #(
  parameter int MAX_VERTICES = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire kumst_pkg::in_item_t               item,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output kumst_pkg::out_item_t                   result,
  input  wire logic                              count_we,
  input  wire logic [kumst_pkg::COUNT_W-1:0]     count_wdata
);

  localparam int MW = $clog2(MAX_VERTICES + 1);
  localparam int CNT_W = (MW > kumst_pkg::COUNT_W) ? MW : kumst_pkg::COUNT_W;

  logic [kumst_pkg::COUNT_W-1:0] vertex_count;
  logic [CNT_W-1:0]              n_eff;
  logic [CNT_W-1:0]              count_ext;
  logic                          clearing;
  logic                          q_full;
  logic                          q_empty;
  logic                          push;
  logic                          pop;
  kumst_pkg::cmd_t               push_cmd;
  kumst_pkg::cmd_t               head;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= kumst_pkg::COUNT_RESET;
    end else if (count_we) begin
      vertex_count <= count_wdata;
    end
  end

  assign count_ext = CNT_W'(vertex_count);

  always_comb begin
    priority if (count_ext < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (count_ext > CNT_W'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = count_ext;
    end
  end

  kumst_front #(
    .WEIGHT_BITS(WEIGHT_BITS),
    .CNT_W(CNT_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .n_eff(n_eff),
    .clearing(clearing),
    .q_full(q_full),
    .push(push),
    .push_cmd(push_cmd)
  );

  kumst_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .full(q_full),
    .pop(pop),
    .head(head),
    .empty(q_empty)
  );

  kumst_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .CNT_W(CNT_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd(head),
    .cmd_empty(q_empty),
    .cmd_pop(pop),
    .n_eff(n_eff),
    .clearing(clearing),
    .result(result),
    .result_valid(result_valid),
    .result_ready(result_ready)
  );

endmodule
`default_nettype wire

// ===== sv/kumst_front.sv =====
`default_nettype none
module kumst_front #(
  parameter int WEIGHT_BITS = 16,
  parameter int CNT_W = 17
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire kumst_pkg::in_item_t item,
  input  wire logic [CNT_W-1:0]    n_eff,
  input  wire logic                clearing,
  input  wire logic                q_full,
  output logic                     push,
  output kumst_pkg::cmd_t          push_cmd
);

  localparam logic [kumst_pkg::WEIGHT_W-1:0] WMASK =
    (WEIGHT_BITS >= kumst_pkg::WEIGHT_W) ? {kumst_pkg::WEIGHT_W{1'b1}} :
    kumst_pkg::WEIGHT_W'((33'd1 << WEIGHT_BITS) - 33'd1);

  logic bad;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= clearing;
    end
  end

  assign item_ready = !q_full && !clearing && !busy;
  assign push = item_valid && item_ready;

  assign bad = (CNT_W'(item.vertex_a) >= n_eff) || (CNT_W'(item.vertex_b) >= n_eff);

  always_comb begin
    push_cmd.vertex_a = item.vertex_a;
    push_cmd.vertex_b = item.vertex_b;
    push_cmd.weight = item.weight & WMASK;
    priority if (item.kind) begin
      push_cmd.op = kumst_pkg::OP_BEGIN;
    end else if (bad) begin
      push_cmd.op = kumst_pkg::OP_BAD;
    end else begin
      push_cmd.op = kumst_pkg::OP_EDGE;
    end
  end

endmodule
`default_nettype wire

// ===== sv/kumst_queue.sv =====
`default_nettype none
module kumst_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire kumst_pkg::cmd_t push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output kumst_pkg::cmd_t      head,
  output logic                 empty
);

  localparam int DEPTH = kumst_pkg::QUEUE_DEPTH;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kumst_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/kumst_back.sv =====
`default_nettype none
module kumst_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int CNT_W = 17
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire kumst_pkg::cmd_t      cmd,
  input  wire logic                 cmd_empty,
  output logic                      cmd_pop,
  input  wire logic [CNT_W-1:0]     n_eff,
  output logic                      clearing,
  output kumst_pkg::out_item_t      result,
  output logic                      result_valid,
  input  wire logic                 result_ready
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SW = kumst_pkg::SUM_W;
  localparam int JW = kumst_pkg::JOINS_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_FA = 3'd2;
  localparam logic [2:0] S_FB = 3'd3;
  localparam logic [2:0] S_LINK = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  // Each entry holds a root flag above the parent index.
  logic [VW:0] links [MAX_VERTICES];

  logic [2:0]                    state;
  logic [VW-1:0]                 clr_idx;
  logic                          clr_reply;
  logic [VW-1:0]                 cur;
  logic [VW-1:0]                 ra;
  logic [VW-1:0]                 vb_idx;
  logic [kumst_pkg::WEIGHT_W-1:0] w_reg;
  logic [SW-1:0]                 sum;
  logic [JW-1:0]                 cnt;
  logic                          done;
  logic                          joined_r;
  logic                          bad_r;
  logic                          out_valid;
  logic [VW:0]                   rd_entry;

  logic          rd_root;
  logic [VW-1:0] rd_parent;
  logic [VW-1:0] rd_addr;
  logic          we;
  logic [VW-1:0] waddr;
  logic [VW:0]   wdata;
  logic          link_ok;
  logic [SW:0]   sum_ext;
  logic [SW-1:0] sum_sat;
  logic [JW-1:0] cnt_inc;
  logic [JW-1:0] cnt_after;

  assign rd_root = rd_entry[VW];
  assign rd_parent = rd_entry[VW-1:0];
  assign link_ok = (ra != cur);
  assign sum_ext = {1'b0, sum} + (SW + 1)'(w_reg);
  assign sum_sat = (sum_ext > (SW + 1)'(kumst_pkg::SUM_MAX)) ? kumst_pkg::SUM_MAX
                                                              : sum_ext[SW-1:0];
  assign cnt_inc = (cnt == kumst_pkg::JOIN_MAX) ? cnt : cnt + JW'(1);
  assign cnt_after = link_ok ? cnt_inc : cnt;
  assign clearing = (state == S_CLEAR);
  assign result_valid = out_valid;

  always_comb begin
    rd_addr = cur;
    we = 1'b0;
    waddr = clr_idx;
    wdata = {1'b1, {VW{1'b0}}};
    cmd_pop = 1'b0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_IDLE: begin
        cmd_pop = !cmd_empty;
        rd_addr = VW'(cmd.vertex_a);
      end
      S_FA: begin
        rd_addr = rd_root ? vb_idx : rd_parent;
      end
      S_FB: begin
        rd_addr = rd_parent;
      end
      S_LINK: begin
        if (link_ok) begin
          we = 1'b1;
          waddr = ra;
          wdata = {1'b0, cur};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      links[waddr] <= wdata;
    end
    rd_entry <= links[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      clr_reply <= 1'b0;
      sum <= '0;
      cnt <= '0;
      done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (result_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + VW'(1);
          if (clr_idx == VW'(MAX_VERTICES - 1)) begin
            state <= clr_reply ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            joined_r <= 1'b0;
            bad_r <= (cmd.op == kumst_pkg::OP_BAD);
            unique case (cmd.op)
              kumst_pkg::OP_BEGIN: begin
                sum <= '0;
                cnt <= '0;
                done <= 1'b0;
                clr_idx <= '0;
                clr_reply <= 1'b1;
                state <= S_CLEAR;
              end
              kumst_pkg::OP_BAD: begin
                state <= S_OUT;
              end
              kumst_pkg::OP_EDGE: begin
                if (done) begin
                  state <= S_OUT;
                end else begin
                  cur <= VW'(cmd.vertex_a);
                  vb_idx <= VW'(cmd.vertex_b);
                  w_reg <= cmd.weight;
                  state <= S_FA;
                end
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_FA: begin
          if (rd_root) begin
            ra <= cur;
            cur <= vb_idx;
            state <= S_FB;
          end else begin
            cur <= rd_parent;
          end
        end
        S_FB: begin
          if (rd_root) begin
            state <= S_LINK;
          end else begin
            cur <= rd_parent;
          end
        end
        S_LINK: begin
          if (link_ok) begin
            joined_r <= 1'b1;
            sum <= sum_sat;
            cnt <= cnt_inc;
          end
          if (CNT_W'(cnt_after) >= n_eff - CNT_W'(1)) begin
            done <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || result_ready) begin
            out_valid <= 1'b1;
            result.joined <= joined_r;
            result.total_weight <= sum;
            result.edges_joined <= cnt;
            result.complete <= done;
            result.bad_vertex <= bad_r;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/kumst_checker.sv =====
`default_nettype none
`include "kruskal_union_find_mst_defines.svh"
module kumst_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 item_ready,
  input wire logic                 result_valid,
  input wire logic                 result_ready,
  input wire kumst_pkg::out_item_t result
);

  `KUMST_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && !result_ready,
    result_valid && $stable(result), "Stalled result changed or dropped.")

  `KUMST_ASSERT_NOW(a_bad_not_joined, clk, rst, result_valid && result.bad_vertex,
    !result.joined, "A bad endpoint request reported a join.")

  `KUMST_ASSERT_NOW(a_join_counted, clk, rst, result_valid && result.joined,
    result.edges_joined != '0, "A join was reported with a zero join count.")

  `KUMST_ASSERT_ALWAYS(a_reset_blocks_input, clk, rst, !item_ready,
    "Input was ready right after reset, during the memory sweep.")

endmodule

bind kruskal_union_find_mst kumst_checker u_kumst_checker (
  .clk(clk),
  .rst(rst),
  .item_ready(item_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result(result)
);
`default_nettype wire
